@@ rtl/segint_pkg.sv @@
// Shared widths, latencies and payload types of the segment intersection pipeline.
package segint_pkg;

  localparam int CW      = 16;            // input coordinate width
  localparam int FRAC    = 8;             // fraction bits of the point
  localparam int OW      = 24;            // point coordinate width
  localparam int DW      = CW + 1;        // coordinate difference width
  localparam int XW      = 2 * DW + 1;    // den, tn, un width
  localparam int D1W     = 2 * CW + 1;    // endpoint cross product width
  localparam int NW      = D1W + DW + 1;  // point numerator width
  localparam int RW      = NW + FRAC;     // scaled numerator magnitude width
  localparam int GEO_LAT = 5;             // stages of the cross product front end
  localparam int DIV_LAT = OW + 4;        // stages of one divider

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic                 hit;
    logic                 parallel;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [XW-1:0] den;
  } geom_t;

endpackage

@@ rtl/segment_intersection.sv @@
// Top level of the streaming two-segment intersection unit.
// Throughput: one request per cycle; a stalled result holds the whole pipeline in place.
// Most of the latency is spent in the restoring dividers' 24 step stages, one quotient bit per stage.
// Reset: synchronous, active low; it clears all valid bits, so no result is pending.
module segment_intersection import segint_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y (16 bits each, signed).
  input  logic [127:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // Fields from bit 0 up: hit, parallel, point_x (24), point_y (24), clipped,
  // then five zero bits.
  output logic [55:0]   out_tdata
);

  // The whole pipeline moves as one unit whenever the output register is free
  // or being emptied in this cycle, so a stall neither drops nor repeats a request.
  logic adv;

  seg_pair_t in_seg;
  logic      geo_valid;
  geom_t     geo;

  logic                 dx_valid, dy_valid;
  logic signed [OW-1:0] qx, qy;
  logic                 clip_x, clip_y;

  // The hit and parallel flags ride alongside the dividers.
  logic [DIV_LAT-1:0] hit_r, par_r;

  logic        out_vld_r;
  logic [55:0] out_data_r;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  assign in_seg.a_start_x = $signed(in_tdata[15:0]);
  assign in_seg.a_start_y = $signed(in_tdata[31:16]);
  assign in_seg.a_end_x   = $signed(in_tdata[47:32]);
  assign in_seg.a_end_y   = $signed(in_tdata[63:48]);
  assign in_seg.b_start_x = $signed(in_tdata[79:64]);
  assign in_seg.b_start_y = $signed(in_tdata[95:80]);
  assign in_seg.b_end_x   = $signed(in_tdata[111:96]);
  assign in_seg.b_end_y   = $signed(in_tdata[127:112]);

  segint_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_seg    (in_seg),
    .out_valid (geo_valid),
    .out_geom  (geo)
  );

  segint_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (geo_valid),
    .num       (geo.nx),
    .den       (geo.den),
    .out_valid (dx_valid),
    .quo       (qx),
    .clip      (clip_x)
  );

  segint_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (geo_valid),
    .num       (geo.ny),
    .den       (geo.den),
    .out_valid (dy_valid),
    .quo       (qy),
    .clip      (clip_y)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= {hit_r[DIV_LAT-2:0], geo.hit};
      par_r <= {par_r[DIV_LAT-2:0], geo.parallel};
    end
  end

  // Parallel lines have no crossing point: the point and clip flag are forced to zero,
  // which also hides the divider's meaningless result for a zero denominator.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {5'b0,
                     !par_r[DIV_LAT-1] && (clip_x || clip_y),
                     par_r[DIV_LAT-1] ? OW'(0) : qy,
                     par_r[DIV_LAT-1] ? OW'(0) : qx,
                     par_r[DIV_LAT-1],
                     hit_r[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dx_valid && dy_valid;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

@@ rtl/segint_geom.sv @@
// Cross product front end: hit test and line intersection numerators.
module segint_geom import segint_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_valid,
  input  seg_pair_t in_seg,
  output logic      out_valid,
  output geom_t     out_geom
);

  logic [GEO_LAT-1:0] vld_r;

  // Stage 1: differences and endpoint copies.
  logic signed [DW-1:0] rx1_r, ry1_r, sx1_r, sy1_r, qx1_r, qy1_r;
  seg_pair_t            seg1_r;
  // Stage 2: products.
  logic signed [2*DW-1:0] rxsy2_r, rysx2_r, qxsy2_r, qysx2_r, qxry2_r, qyrx2_r;
  logic signed [2*CW-1:0] a12_r, a22_r, b12_r, b22_r;
  logic signed [DW-1:0]   rx2_r, ry2_r, sx2_r, sy2_r;
  // Stage 3: cross products.
  logic signed [XW-1:0]  den3_r, tn3_r, un3_r;
  logic signed [D1W-1:0] d13_r, d23_r;
  logic signed [DW-1:0]  rx3_r, ry3_r, sx3_r, sy3_r;
  // Stage 4: hit flag and numerator products.
  logic signed [D1W+DW-1:0] m1x4_r, m2x4_r, m1y4_r, m2y4_r;
  logic signed [XW-1:0]     den4_r;
  logic                     hit4_r, par4_r;
  // Stage 5: numerators.
  geom_t geom5_r;

  logic hit_pos, hit_neg;

  assign hit_pos = (tn3_r >= 0) && (tn3_r <= den3_r) && (un3_r >= 0) && (un3_r <= den3_r);
  assign hit_neg = (tn3_r <= 0) && (tn3_r >= den3_r) && (un3_r <= 0) && (un3_r >= den3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[GEO_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx1_r  <= DW'(in_seg.a_end_x) - DW'(in_seg.a_start_x);
      ry1_r  <= DW'(in_seg.a_end_y) - DW'(in_seg.a_start_y);
      sx1_r  <= DW'(in_seg.b_end_x) - DW'(in_seg.b_start_x);
      sy1_r  <= DW'(in_seg.b_end_y) - DW'(in_seg.b_start_y);
      qx1_r  <= DW'(in_seg.b_start_x) - DW'(in_seg.a_start_x);
      qy1_r  <= DW'(in_seg.b_start_y) - DW'(in_seg.a_start_y);
      seg1_r <= in_seg;

      rxsy2_r <= rx1_r * sy1_r;
      rysx2_r <= ry1_r * sx1_r;
      qxsy2_r <= qx1_r * sy1_r;
      qysx2_r <= qy1_r * sx1_r;
      qxry2_r <= qx1_r * ry1_r;
      qyrx2_r <= qy1_r * rx1_r;
      a12_r   <= seg1_r.a_start_x * seg1_r.a_end_y;
      a22_r   <= seg1_r.a_start_y * seg1_r.a_end_x;
      b12_r   <= seg1_r.b_start_x * seg1_r.b_end_y;
      b22_r   <= seg1_r.b_start_y * seg1_r.b_end_x;
      rx2_r   <= rx1_r;
      ry2_r   <= ry1_r;
      sx2_r   <= sx1_r;
      sy2_r   <= sy1_r;

      den3_r <= XW'(rxsy2_r) - XW'(rysx2_r);
      tn3_r  <= XW'(qxsy2_r) - XW'(qysx2_r);
      un3_r  <= XW'(qxry2_r) - XW'(qyrx2_r);
      d13_r  <= D1W'(a12_r) - D1W'(a22_r);
      d23_r  <= D1W'(b12_r) - D1W'(b22_r);
      rx3_r  <= rx2_r;
      ry3_r  <= ry2_r;
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;

      // Numerators are d2*r - d1*s, since the model's deltas are start minus end.
      m1x4_r <= d13_r * sx3_r;
      m2x4_r <= d23_r * rx3_r;
      m1y4_r <= d13_r * sy3_r;
      m2y4_r <= d23_r * ry3_r;
      den4_r <= den3_r;
      par4_r <= (den3_r == 0);
      hit4_r <= (den3_r > 0) ? hit_pos : ((den3_r < 0) && hit_neg);

      geom5_r.hit      <= hit4_r;
      geom5_r.parallel <= par4_r;
      geom5_r.nx       <= NW'(m2x4_r) - NW'(m1x4_r);
      geom5_r.ny       <= NW'(m2y4_r) - NW'(m1y4_r);
      geom5_r.den      <= den4_r;
    end
  end

  assign out_valid = vld_r[GEO_LAT-1];
  assign out_geom  = geom5_r;

endmodule

@@ rtl/segint_div.sv @@
// Pipelined signed fixed-point divider with saturation, one quotient bit per stage.
module segint_div import segint_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] num,
  input  logic signed [XW-1:0] den,
  output logic                 out_valid,
  output logic signed [OW-1:0] quo,
  output logic                 clip
);

  localparam logic [OW-1:0] HALF = OW'(1) << (OW - 1);

  logic [1:0] pre_vld_r;
  logic       fin_vld_r;

  logic [NW-1:0] nm1_r;
  logic [XW-1:0] dm1_r;
  logic          neg1_r;
  logic [RW-1:0] n2_r, lim2_r;
  logic [XW-1:0] dm2_r;
  logic          neg2_r;

  logic [RW-1:0] rem_r  [0:OW];
  logic [OW-1:0] q_r    [0:OW];
  logic [XW-1:0] dm_r   [0:OW];
  logic          neg_r  [0:OW];
  logic          clip_r [0:OW];
  logic          vld_r  [0:OW];

  logic signed [OW-1:0] quo_r;
  logic                 clipo_r;
  logic [OW-1:0]        qsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r <= '0;
    end else if (adv) begin
      pre_vld_r <= {pre_vld_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm1_r  <= num[NW-1] ? NW'(-num) : NW'(num);
      dm1_r  <= den[XW-1] ? XW'(-den) : XW'(den);
      neg1_r <= num[NW-1] ^ den[XW-1];

      // The quotient overflows when num*2^FRAC reaches (maxmag + 1) * den.
      n2_r   <= {nm1_r, {FRAC{1'b0}}};
      lim2_r <= (RW'(dm1_r) << (OW - 1)) + (neg1_r ? RW'(dm1_r) : RW'(0));
      dm2_r  <= dm1_r;
      neg2_r <= neg1_r;

      rem_r[0]  <= n2_r;
      q_r[0]    <= '0;
      dm_r[0]   <= dm2_r;
      neg_r[0]  <= neg2_r;
      clip_r[0] <= (n2_r >= lim2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= pre_vld_r[1];
    end
  end

  for (genvar k = 0; k < OW; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(dm_r[k]) << (OW - 1 - k);
    assign ge  = (rem_r[k] >= dsh);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= ge ? (rem_r[k] - dsh) : rem_r[k];
        q_r[k+1]    <= q_r[k] | (ge ? (OW'(1) << (OW - 1 - k)) : OW'(0));
        dm_r[k+1]   <= dm_r[k];
        neg_r[k+1]  <= neg_r[k];
        clip_r[k+1] <= clip_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
  end

  assign qsat = clip_r[OW] ? (neg_r[OW] ? HALF : HALF - OW'(1)) : q_r[OW];

  always_ff @(posedge clk) begin
    if (adv) begin
      quo_r   <= neg_r[OW] ? -qsat : qsat;
      clipo_r <= clip_r[OW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= vld_r[OW];
    end
  end

  assign out_valid = fin_vld_r;
  assign quo       = quo_r;
  assign clip      = clipo_r;

endmodule

@@ tb/sv/tb_segment_intersection.sv @@
// Testbench for the streaming two-segment intersection unit.
module tb_segment_intersection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 34;

  // Fields from the most significant end down, so hit lands in bit 0.
  typedef struct packed {
    logic                clipped;
    logic signed [23:0]  point_y;
    logic signed [23:0]  point_x;
    logic                parallel;
    logic                hit;
  } crossing_t;

  typedef logic signed [15:0] coord_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;

  crossing_t expected_q[$];
  int        mismatches;
  int        results_seen;
  int        hits_seen;
  int        parallels_seen;
  int        clips_seen;
  // While set, the result side holds out_tready low; hold_cycles sets how long.
  bit        hold_request;
  int        hold_cycles;
  // While set, the result side takes every result at once.
  bit        drain_fast;

  segment_intersection dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Fixed-point division of num by den, truncated toward zero and saturated
  // to the 24-bit signed point range.
  function automatic logic signed [23:0] scaled_quotient(longint num, longint den,
                                                         inout bit clip);
    bit     neg;
    longint n;
    longint d;
    longint maxmag;
    longint q;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    maxmag = neg ? 64'd8388608 : 64'd8388607;
    if (n / d > (maxmag >>> 8)) begin
      clip = 1'b1;
      q = maxmag;
    end else begin
      // The whole-part check catches quotients too large for the point range before the fraction is formed.
      q = ((n / d) << 8) | (((n % d) << 8) / d);
      if (q > maxmag) begin
        clip = 1'b1;
        q = maxmag;
      end
    end
    return neg ? -q : q;
  endfunction

  // Works out the crossing result of one segment pair.
  function automatic crossing_t crossing_of(logic [127:0] pair);
    longint    c[8];
    longint    rx, ry, sx, sy, qx, qy, den, tn, un, d1, d2, nx, ny;
    bit        clip;
    crossing_t r;
    for (int i = 0; i < 8; i++) c[i] = coord_t'(pair[16*i +: 16]);
    rx = c[2] - c[0];
    ry = c[3] - c[1];
    sx = c[6] - c[4];
    sy = c[7] - c[5];
    qx = c[4] - c[0];
    qy = c[5] - c[1];
    den = rx * sy - ry * sx;
    tn = qx * sy - qy * sx;
    un = qx * ry - qy * rx;
    r = '0;
    clip = 1'b0;
    r.parallel = den == 0;
    if (den != 0) begin
      if (den > 0) r.hit = tn >= 0 && tn <= den && un >= 0 && un <= den;
      else r.hit = tn <= 0 && tn >= den && un <= 0 && un >= den;
      d1 = c[0] * c[3] - c[1] * c[2];
      d2 = c[4] * c[7] - c[5] * c[6];
      nx = d1 * (c[4] - c[6]) - d2 * (c[0] - c[2]);
      ny = d1 * (c[5] - c[7]) - d2 * (c[1] - c[3]);
      r.point_x = scaled_quotient(nx, den, clip);
      r.point_y = scaled_quotient(ny, den, clip);
    end
    r.clipped = clip;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("MISMATCH result %0d %s: got %0d, want %0d", results_seen, what, got, want);
  endtask

  // Sends one request after a random gap; the expectation is queued on acceptance.
  // The valid stays high into the next request when there is no gap.
  task automatic send_pair(logic [127:0] pair, int gap_max = 10);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pair;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(crossing_of(pair));
  endtask

  function automatic logic [127:0] pack_pair(int asx, int asy, int aex, int aey,
                                              int bsx, int bsy, int bex, int bey);
    return {bey[15:0], bex[15:0], bsy[15:0], bsx[15:0],
            aey[15:0], aex[15:0], asy[15:0], asx[15:0]};
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2 * span, 0) - span;
  endfunction

  // Result side: a random wait before each result, a long hold when asked,
  // and a field check.
  initial begin
    crossing_t got;
    crossing_t want;
    int        idle_left;
    out_tready = 1'b0;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (out_tready && out_tvalid) begin
        got = out_tdata[50:0];
        results_seen++;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("MISMATCH result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_q.pop_front();
          if (got.hit != want.hit) report_mismatch("hit", got.hit, want.hit);
          if (got.parallel != want.parallel)
            report_mismatch("parallel", got.parallel, want.parallel);
          if (got.point_x != want.point_x)
            report_mismatch("point_x", got.point_x, want.point_x);
          if (got.point_y != want.point_y)
            report_mismatch("point_y", got.point_y, want.point_y);
          if (got.clipped != want.clipped)
            report_mismatch("clipped", got.clipped, want.clipped);
          if (out_tdata[55:51] != 5'b0) report_mismatch("pad bits", out_tdata[55:51], 0);
          hits_seen += want.hit;
          parallels_seen += want.parallel;
          clips_seen += want.clipped;
        end
        idle_left = drain_fast ? 0 : $urandom_range(10, 0);
      end else if (idle_left > 0) begin
        idle_left--;
      end
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_tready <= (idle_left == 0);
      end
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Extremes of every coordinate, crossings, touches, parallel, collinear
  // and degenerate segments.
  task automatic test_directed();
    send_pair(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
    send_pair(pack_pair(0, 0, 10, 0, 10, 0, 10, 10));
    send_pair(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));
    send_pair(pack_pair(0, 0, 10, 0, 5, 0, 20, 0));
    send_pair(pack_pair(3, 3, 3, 3, 0, 0, 9, 9));
    send_pair(pack_pair(0, 0, 1, 3, 2, 0, 3, 7));
    send_pair(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pack_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
    send_pair(pack_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0));
    send_pair(pack_pair(0, 0, 1, 0, 0, 1, 32767, 2));
    send_pair(pack_pair(0, 0, 1, 1, 0, 1, 1, 2));
    send_pair(pack_pair(-32768, -32768, -32767, -32768, 32767, 32767, 32767, 32766));
    send_pair(pack_pair(0, 0, 2, 2, 2, 0, 1, 1));
    send_pair(pack_pair(0, 0, 4, 0, 1, -1, 3, 1));
    send_pair(pack_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
    send_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pack_pair(0, 0, 3, 0, 0, 0, 0, 3));
    send_pair(pack_pair(0, 0, 1, 2, 5, 5, 6, 9));
  endtask

  // Random pairs: mostly small boxes where hits are common, some full range.
  task automatic test_random(int count);
    int span;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3, 0))
        0: span = 32767;
        1: span = 16;
        default: span = 200;
      endcase
      if (span == 32767) send_pair({$urandom, $urandom, $urandom, $urandom});
      else send_pair(pack_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                               rand_coord(span), rand_coord(span), rand_coord(span),
                               rand_coord(span), rand_coord(span)));
    end
  endtask

  // The result side holds off while requests keep coming, so the pipe fills
  // and in_tready drops; afterwards requests go back to back.
  task automatic test_backpressure();
    hold_cycles = 120;
    hold_request = 1'b1;
    for (int i = 0; i < 80; i++)
      send_pair({$urandom, $urandom, $urandom, $urandom}, 0);
    drain_fast = 1'b1;
    for (int i = 0; i < 100; i++)
      send_pair(pack_pair(rand_coord(50), rand_coord(50), rand_coord(50),
                          rand_coord(50), rand_coord(50), rand_coord(50),
                          rand_coord(50), rand_coord(50)), 0);
    drain_fast = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    results_seen = 0;
    hits_seen = 0;
    parallels_seen = 0;
    clips_seen = 0;
    hold_request = 1'b0;
    hold_cycles = 0;
    drain_fast = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // Pause the sender until every pending result is back.
    wait_drained();
    test_random(600);
    test_backpressure();
    test_random(700);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d results: %0d hits, %0d parallel, %0d clipped points.",
             results_seen, hits_seen, parallels_seen, clips_seen);
    $display("Covered extremes, touching and collinear cases, stalls and a full pipe.");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // The timeout allows for many times the run of about 1500 requests with random gaps and stalls.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
